// ----- sv/beacon_tx_sequencer_fsm_macros.svh -----
// Assertion macros for the beacon sequencer checker.
`ifndef BEACON_TX_SEQUENCER_FSM_MACROS_SVH
`define BEACON_TX_SEQUENCER_FSM_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define BTXS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define BTXS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/btxs_pkg.sv -----
// Types, codes and widths for the beacon transmit sequencer.
`timescale 1ns / 1ps

package btxs_pkg;

   localparam int EVENT_W   = 5;
   localparam int CODE_W    = 4;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [CODE_W-1:0] {
      ST_POWERUP    = 4'd0,
      ST_WAIT_VOLT  = 4'd1,
      ST_CALIBRATE  = 4'd2,
      ST_WAIT_TELEM = 4'd3,
      ST_TELEM      = 4'd4,
      ST_WAIT_PRIM  = 4'd5,
      ST_TX_PRIM    = 4'd6,
      ST_WAIT_SEC   = 4'd7,
      ST_TX_SEC     = 4'd8,
      ST_QRSS       = 4'd9,
      ST_SHUTDOWN   = 4'd10
   } state_type;

   localparam logic [EVENT_W-1:0] EV_WAIT_VOLTAGE    = 5'd1;
   localparam logic [EVENT_W-1:0] EV_SETUP_DONE      = 5'd2;
   localparam logic [EVENT_W-1:0] EV_CAL_DONE        = 5'd3;
   localparam logic [EVENT_W-1:0] EV_CAL_FAIL        = 5'd4;
   localparam logic [EVENT_W-1:0] EV_GPS_LOS         = 5'd5;
   localparam logic [EVENT_W-1:0] EV_STARTUP_CAL_FAIL = 5'd6;
   localparam logic [EVENT_W-1:0] EV_TELEM_TIME      = 5'd7;
   localparam logic [EVENT_W-1:0] EV_TELEM_DONE      = 5'd8;
   localparam logic [EVENT_W-1:0] EV_LOW_VOLT        = 5'd9;
   localparam logic [EVENT_W-1:0] EV_PRIM_TIME       = 5'd10;
   localparam logic [EVENT_W-1:0] EV_PRIM_DONE       = 5'd11;
   localparam logic [EVENT_W-1:0] EV_SLOT_FIRST      = 5'd12;
   localparam logic [EVENT_W-1:0] EV_SLOT_LAST       = 5'd17;
   localparam logic [EVENT_W-1:0] EV_SEC_DONE        = 5'd18;
   localparam logic [EVENT_W-1:0] EV_QRSS_DONE       = 5'd19;

   localparam logic [CODE_W-1:0] ACT_NONE          = 4'd0;
   localparam logic [CODE_W-1:0] ACT_VOLT_WAITLOOP = 4'd1;
   localparam logic [CODE_W-1:0] ACT_QRSS_TX       = 4'd2;
   localparam logic [CODE_W-1:0] ACT_GET_TELEMETRY = 4'd3;
   localparam logic [CODE_W-1:0] ACT_SHUTDOWN      = 4'd4;
   localparam logic [CODE_W-1:0] ACT_TX_MSG1       = 4'd5;
   localparam logic [CODE_W-1:0] ACT_TX_SLOT_FIRST = 4'd6;
   localparam logic [CODE_W-1:0] ACT_CALIBRATE     = 4'd12;
   localparam logic [CODE_W-1:0] ACT_STARTUP_CAL   = 4'd13;
   localparam logic [CODE_W-1:0] ACT_TX_INT_SETUP  = 4'd14;

   localparam logic [CODE_W-1:0] ERR_OK     = 4'd0;
   localparam logic [CODE_W-1:0] ERR_UNIMPL = 4'd10;

   // Outcome of one event against the present state.
   typedef struct packed {
      logic                 move;
      state_type            next_state;
      logic [CODE_W-1:0]    action;
      logic [CODE_W-1:0]    error;
   } step_type;

endpackage

// ----- sv/beacon_tx_sequencer_fsm.sv -----
// Beacon transmit sequencer: stream front end, state registers and result register.
// The result is registered: it appears in the cycle after its event word is accepted.
// Throughput: one event per cycle while results are taken; the single state decode sets that figure.
// req_tready drops only while a held result waits on rsp_tready.
// Reset (synchronous, high): both states go to power-up, self calibration is off,
// and no result is pending.
`timescale 1ns / 1ps

module beacon_tx_sequencer_fsm
   import btxs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [4:0] event_code, [7:5] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] action_code, [7:4] error_code,
                                             // [11:8] current_state, [15:12] prior_state
   input  logic                  csr_wen,
   input  logic                  csr_wdata
);

   state_type             present_ff, present_in;
   state_type             last_ff, last_in;
   logic                  self_cal_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  accept;
   step_type              step;

   btxs_decode u_decode (
      .event_code    (req_tdata[EVENT_W-1:0]),
      .present_state (present_ff),
      .self_cal_en   (self_cal_ff),
      .step          (step)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      present_in   = present_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (accept) begin
         if (step.move) begin
            last_in    = present_ff;
            present_in = step.next_state;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {last_in, present_in, step.error, step.action};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= ST_POWERUP;
         last_ff      <= ST_POWERUP;
         self_cal_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) self_cal_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sv/btxs_decode.sv -----
// Next-state, action and error decode for one event.
`timescale 1ns / 1ps

module btxs_decode
   import btxs_pkg::*;
(
   input  logic [EVENT_W-1:0] event_code,
   input  state_type          present_state,
   input  logic               self_cal_en,
   output step_type           step
);

   logic reject;

   always_comb begin
      step.move       = 1'b0;
      step.next_state = present_state;
      step.action     = ACT_NONE;
      step.error      = ERR_OK;
      reject          = 1'b0;
      case (present_state)
         ST_POWERUP: begin
            if (event_code == EV_WAIT_VOLTAGE) begin
               step.move       = 1'b1;
               step.next_state = ST_WAIT_VOLT;
               step.action     = ACT_VOLT_WAITLOOP;
            end else reject = 1'b1;
         end
         ST_WAIT_VOLT: begin
            if (event_code == EV_SETUP_DONE) begin
               step.move = 1'b1;
               if (self_cal_en) begin
                  step.next_state = ST_CALIBRATE;
                  step.action     = ACT_STARTUP_CAL;
               end else begin
                  step.next_state = ST_WAIT_TELEM;
                  step.action     = ACT_TX_INT_SETUP;
               end
            end else reject = 1'b1;
         end
         ST_CALIBRATE: begin
            if (event_code inside {EV_CAL_DONE, EV_CAL_FAIL}) begin
               step.move       = 1'b1;
               step.next_state = ST_WAIT_TELEM;
            end else if (event_code inside {EV_GPS_LOS, EV_STARTUP_CAL_FAIL}) begin
               step.move       = 1'b1;
               step.next_state = ST_QRSS;
               step.action     = ACT_QRSS_TX;
            end else reject = 1'b1;
         end
         ST_WAIT_TELEM: begin
            if (event_code == EV_TELEM_TIME) begin
               step.move       = 1'b1;
               step.next_state = ST_TELEM;
               step.action     = ACT_GET_TELEMETRY;
            end else reject = 1'b1;
         end
         ST_TELEM: begin
            if (event_code == EV_TELEM_DONE) begin
               step.move       = 1'b1;
               step.next_state = ST_WAIT_PRIM;
            end else if (event_code == EV_LOW_VOLT) begin
               step.move       = 1'b1;
               step.next_state = ST_SHUTDOWN;
               step.action     = ACT_SHUTDOWN;
            end else reject = 1'b1;
         end
         ST_WAIT_PRIM: begin
            if (event_code == EV_PRIM_TIME) begin
               step.move       = 1'b1;
               step.next_state = ST_TX_PRIM;
               step.action     = ACT_TX_MSG1;
            end else reject = 1'b1;
         end
         ST_TX_PRIM: begin
            if (event_code == EV_PRIM_DONE) begin
               step.move       = 1'b1;
               step.next_state = ST_WAIT_SEC;
            end else reject = 1'b1;
         end
         ST_WAIT_SEC: begin
            // Slot events map one to one onto the slot transmit actions.
            if (event_code inside {[EV_SLOT_FIRST:EV_SLOT_LAST]}) begin
               step.move       = 1'b1;
               step.next_state = ST_TX_SEC;
               step.action     = CODE_W'(event_code - EV_SLOT_FIRST) + ACT_TX_SLOT_FIRST;
            end else reject = 1'b1;
         end
         ST_TX_SEC: begin
            if (event_code == EV_SEC_DONE) begin
               step.move = 1'b1;
               if (self_cal_en) begin
                  step.next_state = ST_CALIBRATE;
                  step.action     = ACT_CALIBRATE;
               end else begin
                  step.next_state = ST_WAIT_TELEM;
               end
            end else reject = 1'b1;
         end
         ST_QRSS: begin
            // Drop anything but qrss_done without a fault.
            if (event_code == EV_QRSS_DONE) begin
               step.move       = 1'b1;
               step.next_state = ST_CALIBRATE;
               step.action     = ACT_CALIBRATE;
            end
         end
         default: begin
            step.error = ERR_UNIMPL;
         end
      endcase
      if (reject) step.error = present_state + CODE_W'(1);
   end

endmodule

// ----- sv/btxs_checker.sv -----
// Port-level checks for the beacon sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "beacon_tx_sequencer_fsm_macros.svh"

module btxs_checker
   import btxs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `BTXS_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid,
      "result valid after reset")

   `BTXS_ASSERT(a_word_in_word_out, req_tvalid && req_tready |=> rsp_tvalid,
      "accepted word gave no result")

   `BTXS_ASSERT(a_hold_on_stall,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "stalled result changed")

   `BTXS_ASSERT(a_reject_names_state,
      rsp_tvalid && rsp_tdata[7:4] != ERR_OK && rsp_tdata[7:4] != ERR_UNIMPL |->
         rsp_tdata[11:8] == rsp_tdata[7:4] - 4'd1,
      "reject code does not match state")

   `BTXS_ASSERT(a_unimpl_in_shutdown,
      rsp_tvalid && rsp_tdata[7:4] == ERR_UNIMPL |->
         rsp_tdata[11:8] == ST_SHUTDOWN && rsp_tdata[3:0] == ACT_NONE,
      "unimplemented code outside shutdown")

endmodule

bind beacon_tx_sequencer_fsm btxs_checker u_btxs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- dv/beacon_tx_sequencer_fsm_tb.sv -----
// Self-checking testbench for the beacon transmit sequencer: directed walk, random paths.
`timescale 1ns / 1ps

module beacon_tx_sequencer_fsm_tb;
   import btxs_pkg::*;

   localparam logic [EVENT_W-1:0] EV_NONE         = 5'd0;
   localparam logic [EVENT_W-1:0] EV_FIRST_UNUSED = 5'd20;
   localparam logic [EVENT_W-1:0] EV_TOP          = 5'd31;
   localparam int RESET_CYCLES = 12;
   localparam int LONG_HOLD    = 80;
   localparam int PHASE_WORDS  = 65;
   localparam int PHASES       = 6;
   localparam int DIR_ROWS     = 26;
   localparam int SHOW_LIMIT   = 10;

   // Same bit order as rsp_tdata: action in the low nibble, prior state on top.
   typedef struct packed {
      state_type         prior;
      state_type         cur;
      logic [CODE_W-1:0] error;
      logic [CODE_W-1:0] action;
   } status_word_t;

   typedef struct {
      bit           has_lit;
      status_word_t lit;
   } event_note_t;

   typedef struct {
      logic [EVENT_W-1:0] ev;
      bit                 has_lit;
      status_word_t       lit;
   } dir_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic                  csr_wdata = 1'b0;

   logic         cal_setting = 1'b0;
   state_type    model_cur = ST_POWERUP;
   state_type    model_prior = ST_POWERUP;
   state_type    plan_cur = ST_POWERUP;
   state_type    plan_prior = ST_POWERUP;
   status_word_t pending_status_q[$];
   event_note_t  event_note_q[$];
   int           words_offered = 0;
   int           words_taken = 0;
   int           error_count = 0;
   int           req_idle_pct = 17;
   int           rsp_idle_pct = 17;
   logic         rsp_hold_req = 1'b0;
   logic         rsp_hold_done = 1'b0;
   int           hold_left = 0;

   function automatic logic [CODE_W-1:0] reject_code(state_type s);
      return CODE_W'(s) + 4'd1;
   endfunction

   dir_row_t directed_rows [DIR_ROWS] = '{
      '{EV_NONE, 1'b1,
        '{ST_POWERUP, ST_POWERUP, reject_code(ST_POWERUP), ACT_NONE}},
      '{EV_TOP, 1'b1,
        '{ST_POWERUP, ST_POWERUP, reject_code(ST_POWERUP), ACT_NONE}},
      '{EV_WAIT_VOLTAGE, 1'b1,
        '{ST_POWERUP, ST_WAIT_VOLT, ERR_OK, ACT_VOLT_WAITLOOP}},
      '{EV_FIRST_UNUSED, 1'b1,
        '{ST_POWERUP, ST_WAIT_VOLT, reject_code(ST_WAIT_VOLT), ACT_NONE}},
      '{EV_SETUP_DONE, 1'b0, '0},
      '{EV_NONE, 1'b1,
        '{ST_WAIT_VOLT, ST_CALIBRATE, reject_code(ST_CALIBRATE), ACT_NONE}},
      '{EV_GPS_LOS, 1'b0, '0},
      // QRSS swallows anything but its own done event
      '{EV_TOP, 1'b1, '{ST_CALIBRATE, ST_QRSS, ERR_OK, ACT_NONE}},
      '{EV_NONE, 1'b0, '0},
      '{EV_QRSS_DONE, 1'b0, '0},
      '{EV_STARTUP_CAL_FAIL, 1'b0, '0},
      '{EV_QRSS_DONE, 1'b0, '0},
      '{EV_CAL_FAIL, 1'b0, '0},
      '{EV_SEC_DONE, 1'b1,
        '{ST_CALIBRATE, ST_WAIT_TELEM, reject_code(ST_WAIT_TELEM), ACT_NONE}},
      '{EV_TELEM_TIME, 1'b0, '0},
      '{EV_TOP, 1'b1,
        '{ST_WAIT_TELEM, ST_TELEM, reject_code(ST_TELEM), ACT_NONE}},
      '{EV_TELEM_DONE, 1'b0, '0},
      '{EV_NONE, 1'b1,
        '{ST_TELEM, ST_WAIT_PRIM, reject_code(ST_WAIT_PRIM), ACT_NONE}},
      '{EV_PRIM_TIME, 1'b0, '0},
      '{EV_SLOT_FIRST, 1'b1,
        '{ST_WAIT_PRIM, ST_TX_PRIM, reject_code(ST_TX_PRIM), ACT_NONE}},
      '{EV_PRIM_DONE, 1'b0, '0},
      '{EV_SEC_DONE, 1'b1,
        '{ST_TX_PRIM, ST_WAIT_SEC, reject_code(ST_WAIT_SEC), ACT_NONE}},
      '{EV_SLOT_LAST, 1'b0, '0},
      '{EV_SLOT_LAST, 1'b1,
        '{ST_WAIT_SEC, ST_TX_SEC, reject_code(ST_TX_SEC), ACT_NONE}},
      '{EV_SEC_DONE, 1'b0, '0},
      '{EV_CAL_DONE, 1'b0, '0}
   };

   beacon_tx_sequencer_fsm uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [4:0] event_code, [7:5] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [3:0] action, [7:4] error, [11:8] state, [15:12] prior
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Status word that one event produces from the given state pair.
   function automatic status_word_t next_beacon_status(state_type cur, state_type prior,
                                                       logic cal_en,
                                                       logic [EVENT_W-1:0] ev);
      status_word_t w;
      state_type    nxt;
      bit           moved;
      bit           reject;
      w.action = ACT_NONE;
      w.error  = ERR_OK;
      nxt      = cur;
      moved    = 1'b0;
      reject   = 1'b0;
      case (cur)
         ST_POWERUP: begin
            if (ev == EV_WAIT_VOLTAGE) begin
               nxt = ST_WAIT_VOLT; w.action = ACT_VOLT_WAITLOOP; moved = 1'b1;
            end else reject = 1'b1;
         end
         ST_WAIT_VOLT: begin
            if (ev == EV_SETUP_DONE) begin
               moved = 1'b1;
               if (cal_en) begin
                  nxt = ST_CALIBRATE; w.action = ACT_STARTUP_CAL;
               end else begin
                  nxt = ST_WAIT_TELEM; w.action = ACT_TX_INT_SETUP;
               end
            end else reject = 1'b1;
         end
         ST_CALIBRATE: begin
            if (ev == EV_CAL_DONE || ev == EV_CAL_FAIL) begin
               nxt = ST_WAIT_TELEM; moved = 1'b1;
            end else if (ev == EV_GPS_LOS || ev == EV_STARTUP_CAL_FAIL) begin
               nxt = ST_QRSS; w.action = ACT_QRSS_TX; moved = 1'b1;
            end else reject = 1'b1;
         end
         ST_WAIT_TELEM: begin
            if (ev == EV_TELEM_TIME) begin
               nxt = ST_TELEM; w.action = ACT_GET_TELEMETRY; moved = 1'b1;
            end else reject = 1'b1;
         end
         ST_TELEM: begin
            if (ev == EV_TELEM_DONE) begin
               nxt = ST_WAIT_PRIM; moved = 1'b1;
            end else if (ev == EV_LOW_VOLT) begin
               nxt = ST_SHUTDOWN; w.action = ACT_SHUTDOWN; moved = 1'b1;
            end else reject = 1'b1;
         end
         ST_WAIT_PRIM: begin
            if (ev == EV_PRIM_TIME) begin
               nxt = ST_TX_PRIM; w.action = ACT_TX_MSG1; moved = 1'b1;
            end else reject = 1'b1;
         end
         ST_TX_PRIM: begin
            if (ev == EV_PRIM_DONE) begin
               nxt = ST_WAIT_SEC; moved = 1'b1;
            end else reject = 1'b1;
         end
         ST_WAIT_SEC: begin
            if (ev >= EV_SLOT_FIRST && ev <= EV_SLOT_LAST) begin
               nxt = ST_TX_SEC; moved = 1'b1;
               w.action = ACT_TX_SLOT_FIRST + CODE_W'(ev - EV_SLOT_FIRST);
            end else reject = 1'b1;
         end
         ST_TX_SEC: begin
            if (ev == EV_SEC_DONE) begin
               moved = 1'b1;
               if (cal_en) begin
                  nxt = ST_CALIBRATE; w.action = ACT_CALIBRATE;
               end else nxt = ST_WAIT_TELEM;
            end else reject = 1'b1;
         end
         ST_QRSS: begin
            if (ev == EV_QRSS_DONE) begin
               nxt = ST_CALIBRATE; w.action = ACT_CALIBRATE; moved = 1'b1;
            end
         end
         default: w.error = ERR_UNIMPL;
      endcase
      if (reject) w.error = reject_code(cur);
      w.cur   = moved ? nxt : cur;
      w.prior = moved ? cur : prior;
      return w;
   endfunction

   // Mostly the event that advances the sequence, otherwise noise.
   function automatic logic [EVENT_W-1:0] pick_event(state_type s, bit allow_down);
      logic [EVENT_W-1:0] ev;
      if ($urandom_range(99) < 25) begin
         ev = EVENT_W'($urandom_range(EV_TOP));
         // hold off shutdown until the closing phase, it cannot be left
         if (s == ST_TELEM && ev == EV_LOW_VOLT && !allow_down) ev = EV_TELEM_DONE;
         return ev;
      end
      case (s)
         ST_POWERUP:    ev = EV_WAIT_VOLTAGE;
         ST_WAIT_VOLT:  ev = EV_SETUP_DONE;
         ST_CALIBRATE: begin
            case ($urandom_range(3))
               0:       ev = EV_CAL_DONE;
               1:       ev = EV_CAL_FAIL;
               2:       ev = EV_GPS_LOS;
               default: ev = EV_STARTUP_CAL_FAIL;
            endcase
         end
         ST_WAIT_TELEM: ev = EV_TELEM_TIME;
         ST_TELEM:      ev = allow_down ? EV_LOW_VOLT : EV_TELEM_DONE;
         ST_WAIT_PRIM:  ev = EV_PRIM_TIME;
         ST_TX_PRIM:    ev = EV_PRIM_DONE;
         ST_WAIT_SEC:   ev = EVENT_W'($urandom_range(EV_SLOT_LAST, EV_SLOT_FIRST));
         ST_TX_SEC:     ev = EV_SEC_DONE;
         ST_QRSS:       ev = EV_QRSS_DONE;
         default:       ev = EVENT_W'($urandom_range(EV_TOP));
      endcase
      return ev;
   endfunction

   task automatic send_word(logic [EVENT_W-1:0] ev, bit has_lit, status_word_t lit);
      event_note_t  n;
      status_word_t w;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      n.has_lit = has_lit;
      n.lit     = lit;
      event_note_q.push_back(n);
      w = next_beacon_status(plan_cur, plan_prior, cal_setting, ev);
      plan_cur   = w.cur;
      plan_prior = w.prior;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(ev);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_offered++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_taken != words_offered || pending_status_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_calibration(logic enable);
      wait_for_results();
      csr_wen     <= 1'b1;
      csr_wdata   <= enable;
      cal_setting = enable;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Receiver: random back-pressure plus one long hold-off on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (rsp_hold_req && !rsp_hold_done) begin
         rsp_hold_done <= 1'b1;
         hold_left     <= LONG_HOLD;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : status_check
      status_word_t got;
      status_word_t want;
      status_word_t pred;
      event_note_t  n;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = status_word_t'(rsp_tdata);
            if (pending_status_q.size() == 0) begin
               error_count++;
               if (error_count <= SHOW_LIMIT)
                  $display("%0t unexpected status word %h", $realtime, rsp_tdata);
            end else begin
               want = pending_status_q.pop_front();
               if (got.action !== want.action || got.error !== want.error ||
                   got.cur !== want.cur || got.prior !== want.prior) begin
                  error_count++;
                  if (error_count <= SHOW_LIMIT)
                     $display({"%0t mismatch: exp act=%0d err=%0d st=%0d prior=%0d,",
                               " got act=%0d err=%0d st=%0d prior=%0d"},
                              $realtime, want.action, want.error, want.cur, want.prior,
                              got.action, got.error, got.cur, got.prior);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            n    = event_note_q.pop_front();
            pred = next_beacon_status(model_cur, model_prior, cal_setting,
                                      req_tdata[EVENT_W-1:0]);
            model_cur   = pred.cur;
            model_prior = pred.prior;
            pending_status_q.push_back(n.has_lit ? n.lit : pred);
            words_taken++;
         end
      end
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_calibration(1'b1);
      foreach (directed_rows[i])
         send_word(directed_rows[i].ev, directed_rows[i].has_lit, directed_rows[i].lit);

      for (int p = 0; p < PHASES; p++) begin
         write_calibration(p[0]);
         req_idle_pct = (p == 2) ? 0 : 17;
         rsp_idle_pct = (p == 2) ? 0 : 17;
         // sender keeps offering while the receiver holds off, input must stall
         if (p == 3) rsp_hold_req <= 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++)
            send_word(pick_event(plan_cur, 1'b0), 1'b0, '0);
      end

      // shutdown is terminal, so it closes the run
      while (plan_cur != ST_SHUTDOWN)
         send_word(pick_event(plan_cur, 1'b1), 1'b0, '0);
      repeat (12) send_word(pick_event(plan_cur, 1'b1), 1'b0, '0);

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_status_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
